### hw/rtl/drive_axis_pt2_simulator_unit_macros.svh
// Assertion helpers for the drive axis block.
`ifndef DRIVE_AXIS_PT2_SIMULATOR_UNIT_MACROS_SVH
`define DRIVE_AXIS_PT2_SIMULATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define DAP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define DAP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/dap_pkg.sv
package dap_pkg;

  localparam int TICK_FRAC = 24;
  localparam int ACC_W = 128;
  localparam logic [63:0] QUOT_CAP = 64'h4000_0000_0000_0000;

  localparam logic signed [31:0] RST_GAIN_K = 32'sd65536;
  localparam logic [30:0] RST_TWO_DAMPING_TIME = 31'd6554;
  localparam logic [30:0] RST_TIME_CONST_SQUARED = 31'd164;
  localparam logic [30:0] RST_MAX_POSITION = 31'd65536000;
  localparam logic signed [31:0] RST_MIN_VELOCITY = -32'sd6553600;
  localparam logic [30:0] RST_MAX_VELOCITY = 31'd6553600;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_SET_VEL  = 3'd1,
    MODE_ENABLE   = 3'd2,
    MODE_DISABLE  = 3'd3,
    MODE_LOAD_POS = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CFG_GAIN_K             = 3'd0,
    CFG_TWO_DAMPING_TIME   = 3'd1,
    CFG_TIME_CONST_SQUARED = 3'd2,
    CFG_MAX_POSITION       = 3'd3,
    CFG_MIN_VELOCITY       = 3'd4,
    CFG_MAX_VELOCITY       = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_H_START,
    ST_H_RUN,
    ST_A_ISS,
    ST_A_WAIT,
    ST_B_ISS,
    ST_B_WAIT,
    ST_K_ISS,
    ST_K_WAIT,
    ST_U,
    ST_NUM_ISS,
    ST_NUM_WAIT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_P_ISS,
    ST_P_WAIT,
    ST_P_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       clear;
    logic       sub;
    logic [1:0] shift;
  } mac_ctl_t;

  // min limit applied last, so it wins when the limits cross
  function automatic logic signed [31:0] clamp_vel(input logic signed [63:0] x,
                                                   input logic [30:0] vmax,
                                                   input logic signed [31:0] vmin);
    logic signed [63:0] r;
    r = x;
    if (r > $signed({33'b0, vmax})) r = $signed({33'b0, vmax});
    if (r < 64'(vmin)) r = 64'(vmin);
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_pos(input logic signed [41:0] x,
                                                   input logic [30:0] pmax);
    logic signed [41:0] hi;
    logic signed [41:0] r;
    hi = $signed({11'b0, pmax});
    r = x;
    if (r > hi) r = hi;
    if (r < -hi) r = -hi;
    return r[31:0];
  endfunction

endpackage

### hw/rtl/drive_axis_pt2_simulator_unit.sv
// One drive axis with a second-order velocity lag, Q16.16 by default. Every request returns
// one result (position, velocity, enabled) after its update. Set-velocity, enable, disable
// and load-position requests update the axis when accepted and go straight to the result state.
// A tick on an enabled axis with n fine steps first divides the tick length by n, then runs
// the fine steps one by one; the 128-step restoring divider that forms each new velocity
// (unless the denominator is zero) dominates, and one 32x32 multiplier is shared by all
// products of a step. The input stalls until the result is handed to the output register.
`include "drive_axis_pt2_simulator_unit_macros.svh"

module drive_axis_pt2_simulator_unit #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_FINE_STEPS = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [31:0]        time_step,
  input  logic [7:0]         fine_steps,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic               enabled,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dap_pkg::state_t state, state_next;

  logic signed [31:0] gain_k;
  logic [30:0] two_damping_time;
  logic [30:0] time_const_squared;
  logic [30:0] max_position;
  logic signed [31:0] min_velocity;
  logic [30:0] max_velocity;

  logic signed [31:0] cur_position;
  logic signed [31:0] cur_velocity;
  logic signed [31:0] prev_velocity;
  logic signed [31:0] velocity_command;
  logic axis_enabled;

  logic [31:0] tick_len;
  logic [7:0] steps_left;
  logic [31:0] h;
  logic [2:0] pp_idx;
  logic [63:0] a_term;
  logic [63:0] b_term;
  logic [63:0] den;
  logic [63:0] u_mag;
  logic u_neg;
  logic num_neg;
  logic signed [31:0] nv;

  logic in_accept;
  logic out_load;
  logic [7:0] n_eff;

  dap_pkg::mac_ctl_t mac_ctl;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [dap_pkg::ACC_W-1:0] acc;

  logic div_start;
  logic div_busy;
  logic div_done;
  logic [127:0] div_num;
  logic [63:0] div_den;
  logic [127:0] quot;

  logic [31:0] k_mag;
  logic [31:0] cmd_mag;
  logic k_neg;
  logic [31:0] v_mag;
  logic [63:0] v_shift;
  logic signed [33:0] dv;
  logic signed [64:0] u_sum;
  logic signed [64:0] u_abs;
  logic [63:0] den_sum;
  logic [dap_pkg::ACC_W-1:0] acc_mag;
  logic [63:0] q_sat;
  logic [63:0] q_shr;
  logic signed [63:0] q_signed;
  logic signed [32:0] vsum;
  logic [32:0] s_mag;
  logic [39:0] dp;
  logic signed [41:0] np;
  logic [63:0] x_sel;
  logic [63:0] y_sel;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != dap_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load = (state == dap_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign n_eff = ({24'b0, fine_steps} > MAX_FINE_STEPS) ? 8'(MAX_FINE_STEPS) : fine_steps;

  assign k_mag = gain_k[31] ? (~gain_k + 32'd1) : gain_k;
  assign cmd_mag = velocity_command[31] ? (~velocity_command + 32'd1) : velocity_command;
  assign k_neg = gain_k[31] ^ velocity_command[31];
  assign v_mag = cur_velocity[31] ? (~cur_velocity + 32'd1) : cur_velocity;
  assign v_shift = 64'(v_mag) << FRAC_BITS;

  assign dv = (34'(cur_velocity) <<< 1) - 34'(prev_velocity);
  assign u_sum = $signed(acc[64:0]) + (65'(dv) <<< FRAC_BITS);
  assign u_abs = u_sum[64] ? -u_sum : u_sum;
  assign den_sum = a_term + b_term + {11'b0, time_const_squared, 22'b0};

  assign acc_mag = acc[dap_pkg::ACC_W-1] ? -acc : acc;
  assign q_sat = (quot[127:64] != 64'd0 || quot[63:0] > dap_pkg::QUOT_CAP)
                 ? dap_pkg::QUOT_CAP : quot[63:0];
  assign q_shr = q_sat >> FRAC_BITS;
  assign q_signed = num_neg ? -$signed(q_shr) : $signed(q_shr);

  assign vsum = 33'(cur_velocity) + 33'(nv);
  assign s_mag = vsum[32] ? -vsum : vsum;
  assign dp = acc[dap_pkg::TICK_FRAC+40:dap_pkg::TICK_FRAC+1];
  assign np = vsum[32] ? 42'(cur_position) - $signed({2'b0, dp})
                       : 42'(cur_position) + $signed({2'b0, dp});

  assign div_start = (state == dap_pkg::ST_H_START) || (state == dap_pkg::ST_DIV_LOAD);
  assign div_num = (state == dap_pkg::ST_H_START) ? {96'b0, tick_len} : acc_mag;
  assign div_den = (state == dap_pkg::ST_H_START) ? {56'b0, steps_left} : den;

  assign x_sel = pp_idx[2] ? b_term : a_term;
  assign y_sel = pp_idx[2] ? v_shift : u_mag;

  dap_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  dap_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_ctl = '0;
    op_a = h;
    op_b = h;
    unique case (state)
      dap_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (mode == dap_pkg::MODE_TICK && axis_enabled && n_eff != 8'd0) begin
            state_next = dap_pkg::ST_H_START;
          end else begin
            state_next = dap_pkg::ST_DONE;
          end
        end
      end
      dap_pkg::ST_H_START: state_next = dap_pkg::ST_H_RUN;
      dap_pkg::ST_H_RUN: begin
        if (div_done) state_next = dap_pkg::ST_A_ISS;
      end
      dap_pkg::ST_A_ISS: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.clear = 1'b1;
        state_next = dap_pkg::ST_A_WAIT;
      end
      dap_pkg::ST_A_WAIT: state_next = dap_pkg::ST_B_ISS;
      dap_pkg::ST_B_ISS: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.clear = 1'b1;
        op_a = {1'b0, two_damping_time};
        state_next = dap_pkg::ST_B_WAIT;
      end
      dap_pkg::ST_B_WAIT: state_next = dap_pkg::ST_K_ISS;
      dap_pkg::ST_K_ISS: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_ctl.sub = k_neg;
        op_a = k_mag;
        op_b = cmd_mag;
        state_next = dap_pkg::ST_K_WAIT;
      end
      dap_pkg::ST_K_WAIT: state_next = dap_pkg::ST_U;
      dap_pkg::ST_U: begin
        state_next = (den_sum == 64'd0) ? dap_pkg::ST_P_ISS : dap_pkg::ST_NUM_ISS;
      end
      dap_pkg::ST_NUM_ISS: begin
        // signed numerator: +-a*|u| then +-b*|v|<<F
        mac_ctl.valid = 1'b1;
        mac_ctl.clear = (pp_idx == 3'd0);
        mac_ctl.sub = pp_idx[2] ? cur_velocity[31] : u_neg;
        mac_ctl.shift = {1'b0, pp_idx[1]} + {1'b0, pp_idx[0]};
        op_a = pp_idx[1] ? x_sel[63:32] : x_sel[31:0];
        op_b = pp_idx[0] ? y_sel[63:32] : y_sel[31:0];
        if (pp_idx == 3'd7) state_next = dap_pkg::ST_NUM_WAIT;
      end
      dap_pkg::ST_NUM_WAIT: state_next = dap_pkg::ST_DIV_LOAD;
      dap_pkg::ST_DIV_LOAD: state_next = dap_pkg::ST_DIV_RUN;
      dap_pkg::ST_DIV_RUN: begin
        if (div_done) state_next = dap_pkg::ST_P_ISS;
      end
      dap_pkg::ST_P_ISS: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.clear = !pp_idx[0];
        mac_ctl.shift = {1'b0, pp_idx[0]};
        op_b = pp_idx[0] ? {31'b0, s_mag[32]} : s_mag[31:0];
        if (pp_idx[0]) state_next = dap_pkg::ST_P_WAIT;
      end
      dap_pkg::ST_P_WAIT: state_next = dap_pkg::ST_P_UPD;
      dap_pkg::ST_P_UPD: begin
        state_next = (steps_left == 8'd1) ? dap_pkg::ST_DONE : dap_pkg::ST_A_ISS;
      end
      dap_pkg::ST_DONE: begin
        if (out_load) state_next = dap_pkg::ST_IDLE;
      end
      default: state_next = dap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k <= dap_pkg::RST_GAIN_K;
      two_damping_time <= dap_pkg::RST_TWO_DAMPING_TIME;
      time_const_squared <= dap_pkg::RST_TIME_CONST_SQUARED;
      max_position <= dap_pkg::RST_MAX_POSITION;
      min_velocity <= dap_pkg::RST_MIN_VELOCITY;
      max_velocity <= dap_pkg::RST_MAX_VELOCITY;
      cur_position <= '0;
      cur_velocity <= '0;
      prev_velocity <= '0;
      velocity_command <= '0;
      axis_enabled <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dap_pkg::CFG_GAIN_K: gain_k <= cfg_data;
          dap_pkg::CFG_TWO_DAMPING_TIME: two_damping_time <= cfg_data[30:0];
          dap_pkg::CFG_TIME_CONST_SQUARED: time_const_squared <= cfg_data[30:0];
          dap_pkg::CFG_MAX_POSITION: max_position <= cfg_data[30:0];
          dap_pkg::CFG_MIN_VELOCITY: min_velocity <= cfg_data;
          dap_pkg::CFG_MAX_VELOCITY: max_velocity <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        unique case (mode)
          dap_pkg::MODE_SET_VEL: velocity_command <= value;
          dap_pkg::MODE_ENABLE: axis_enabled <= 1'b1;
          dap_pkg::MODE_DISABLE: begin
            axis_enabled <= 1'b0;
            velocity_command <= '0;
            cur_velocity <= '0;
          end
          dap_pkg::MODE_LOAD_POS: begin
            axis_enabled <= 1'b0;
            velocity_command <= '0;
            cur_velocity <= '0;
            cur_position <= dap_pkg::clamp_pos(42'(value), max_position);
          end
          default: ;
        endcase
      end
      if (state == dap_pkg::ST_P_UPD) begin
        cur_position <= dap_pkg::clamp_pos(np, max_position);
        prev_velocity <= cur_velocity;
        cur_velocity <= nv;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dap_pkg::ST_NUM_ISS || state == dap_pkg::ST_P_ISS) begin
      pp_idx <= pp_idx + 3'd1;
    end else begin
      pp_idx <= '0;
    end
    if (in_accept && mode == dap_pkg::MODE_TICK) begin
      tick_len <= time_step;
      steps_left <= n_eff;
    end
    if (state == dap_pkg::ST_H_RUN && div_done) h <= quot[31:0];
    if (state == dap_pkg::ST_B_ISS) a_term <= acc[63:0] >> (26 - FRAC_BITS);
    if (state == dap_pkg::ST_K_ISS) b_term <= acc[63:0] >> 2;
    if (state == dap_pkg::ST_U) begin
      u_mag <= u_abs[63:0];
      u_neg <= u_sum[64];
      den <= den_sum;
      if (den_sum == 64'd0) begin
        nv <= dap_pkg::clamp_vel(64'(cur_velocity), max_velocity, min_velocity);
      end
    end
    if (state == dap_pkg::ST_DIV_LOAD) num_neg <= acc[dap_pkg::ACC_W-1];
    if (state == dap_pkg::ST_DIV_RUN && div_done) begin
      nv <= dap_pkg::clamp_vel(q_signed, max_velocity, min_velocity);
    end
    if (state == dap_pkg::ST_P_UPD) steps_left <= steps_left - 8'd1;
    if (out_load) begin
      position <= cur_position;
      velocity <= cur_velocity;
      enabled <= axis_enabled;
    end
  end

  `DAP_ASSERT_IMPL(a_div_restart, div_start, !div_busy, "divider restarted while busy")
  `DAP_ASSERT_IMPL(a_num_den, state == dap_pkg::ST_NUM_ISS, den != 64'd0, "division by zero")
  `DAP_ASSERT_NEXT(a_tick_off, in_accept && mode == dap_pkg::MODE_TICK && !axis_enabled, state == dap_pkg::ST_DONE, "tick on disabled axis ran")

endmodule

### hw/rtl/dap_mac.sv
module dap_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  dap_pkg::mac_ctl_t            ctl,
  input  logic [31:0]                  op_a,
  input  logic [31:0]                  op_b,
  output logic [dap_pkg::ACC_W-1:0]    acc
);

  dap_pkg::mac_ctl_t ctl_q;
  logic [63:0] prod;
  logic [dap_pkg::ACC_W-1:0] addend;
  logic [dap_pkg::ACC_W-1:0] base;
  logic [dap_pkg::ACC_W-1:0] acc_next;

  always_comb begin
    addend = dap_pkg::ACC_W'(prod) << {ctl_q.shift, 5'b0};
    base = ctl_q.clear ? '0 : acc;
    if (!ctl_q.valid) begin
      acc_next = acc;
    end else if (ctl_q.sub) begin
      acc_next = base - addend;
    end else begin
      acc_next = base + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    acc <= acc_next;
  end

endmodule

### hw/rtl/dap_div.sv
module dap_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic         done,
  output logic [127:0] quot
);

  localparam int NUM_W = 128;
  localparam logic [6:0] LAST = 7'(NUM_W - 1);

  logic [NUM_W-1:0] nq;
  logic [63:0] rem;
  logic [63:0] dreg;
  logic [63:0] rem_sh;
  logic [6:0] cnt;
  logic ge;

  assign rem_sh = {rem[62:0], nq[NUM_W-1]};
  assign ge = rem_sh >= dreg;
  assign quot = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq <= num;
      rem <= '0;
      dreg <= den;
    end else if (busy) begin
      nq <= {nq[NUM_W-2:0], ge};
      rem <= ge ? rem_sh - dreg : rem_sh;
    end
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNDEF5 = 3'd5;
  localparam logic [2:0] MODE_UNDEF6 = 3'd6;
  localparam logic [2:0] MODE_UNDEF7 = 3'd7;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] mode = dap_pkg::MODE_TICK;
  logic [31:0] time_step = '0;
  logic [7:0] fine_steps = 8'd1;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic enabled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = dap_pkg::CFG_GAIN_K;
  logic [31:0] cfg_data = '0;

  drive_axis_pt2_simulator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .time_step(time_step), .fine_steps(fine_steps), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .velocity(velocity), .enabled(enabled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic en;
  } axis_state_t;

  typedef struct {
    logic [2:0] md;
    logic [31:0] ts;
    logic [7:0] fs;
    logic [31:0] val;
    bit typed;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic en;
  } stim_row_t;

  axis_state_t axis_q[$];
  int errors = 0;
  longint cycles = 0;

  // predictor copy of registers and state
  logic signed [31:0] p_gain;
  logic [30:0] p_tdt, p_tcs, p_pmax, p_vmax;
  logic signed [31:0] p_vmin;
  logic signed [31:0] p_pos, p_vel, p_prev, p_cmd;
  bit p_en;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void fine_step(input logic [31:0] h);
    logic [63:0] a, b, c, den, um, vm, sm, qm;
    logic [127:0] t1, t2, num, q, dp;
    longint u, nv, sum, np, lim;
    bit un, cn, neg;
    a = (64'(h) * 64'(h)) >> 10;
    b = (64'(p_tdt) * 64'(h)) >> 2;
    c = 64'(p_tcs) << 22;
    den = a + b + c;
    if (den == 0) begin
      nv = longint'(p_vel);
    end else begin
      u = longint'(p_gain) * longint'(p_cmd)
        + (2 * longint'(p_vel) - longint'(p_prev)) * 65536;
      un = u < 0;
      cn = p_vel < 0;
      um = un ? 64'(-u) : 64'(u);
      vm = cn ? 64'(-longint'(p_vel)) : 64'(longint'(p_vel));
      t1 = 128'(a) * 128'(um);
      t2 = 128'(b) * 128'(vm << 16);
      if (un == cn) begin
        num = t1 + t2;
        neg = un;
      end else if (t1 >= t2) begin
        num = t1 - t2;
        neg = un;
      end else begin
        num = t2 - t1;
        neg = cn;
      end
      q = num / 128'(den);
      if (q > 128'(dap_pkg::QUOT_CAP)) q = 128'(dap_pkg::QUOT_CAP);
      qm = q[63:0] >> 16;
      nv = neg ? -longint'(qm) : longint'(qm);
    end
    if (nv > longint'(p_vmax)) nv = longint'(p_vmax);
    if (nv < longint'(p_vmin)) nv = longint'(p_vmin);
    sum = longint'(p_vel) + nv;
    sm = sum < 0 ? 64'(-sum) : 64'(sum);
    dp = (128'(sm) * 128'(h)) >> 25;
    np = sum < 0 ? longint'(p_pos) - longint'(dp[63:0]) : longint'(p_pos) + longint'(dp[63:0]);
    lim = longint'(p_pmax);
    if (np > lim) np = lim;
    if (np < -lim) np = -lim;
    p_pos = np[31:0];
    p_prev = p_vel;
    p_vel = nv[31:0];
  endfunction

  function automatic axis_state_t predict_axis(input logic [2:0] md, input logic [31:0] ts,
                                               input logic [7:0] fs, input logic [31:0] val);
    axis_state_t r;
    logic [31:0] h;
    longint lp;
    case (md)
      dap_pkg::MODE_TICK: begin
        if (p_en && fs != 0) begin
          h = ts / 32'(fs);
          for (int i = 0; i < int'(fs); i++) fine_step(h);
        end
      end
      dap_pkg::MODE_SET_VEL: p_cmd = val;
      dap_pkg::MODE_ENABLE: p_en = 1'b1;
      dap_pkg::MODE_DISABLE: begin
        p_en = 1'b0;
        p_cmd = '0;
        p_vel = '0;
      end
      dap_pkg::MODE_LOAD_POS: begin
        p_en = 1'b0;
        p_cmd = '0;
        p_vel = '0;
        lp = longint'($signed(val));
        if (lp > longint'(p_pmax)) lp = longint'(p_pmax);
        if (lp < -longint'(p_pmax)) lp = -longint'(p_pmax);
        p_pos = lp[31:0];
      end
      default: ;
    endcase
    r.pos = p_pos;
    r.vel = p_vel;
    r.en = p_en;
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_request(input logic [2:0] md, input logic [31:0] ts,
                              input logic [7:0] fs, input logic [31:0] val);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    time_step <= ts;
    fine_steps <= fs;
    value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_row(input stim_row_t row);
    axis_state_t e;
    e = predict_axis(row.md, row.ts, row.fs, row.val);
    if (row.typed) begin
      e.pos = row.pos;
      e.vel = row.vel;
      e.en = row.en;
    end
    axis_q.push_back(e);
    send_request(row.md, row.ts, row.fs, row.val);
  endtask

  task automatic write_reg(input dap_pkg::cfg_idx_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dap_pkg::CFG_GAIN_K: p_gain = d;
      dap_pkg::CFG_TWO_DAMPING_TIME: p_tdt = d[30:0];
      dap_pkg::CFG_TIME_CONST_SQUARED: p_tcs = d[30:0];
      dap_pkg::CFG_MAX_POSITION: p_pmax = d[30:0];
      dap_pkg::CFG_MIN_VELOCITY: p_vmin = d;
      dap_pkg::CFG_MAX_VELOCITY: p_vmax = d[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (axis_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg(input dap_pkg::cfg_idx_t idx);
    int r;
    logic [31:0] lo, hi, dflt;
    case (idx)
      dap_pkg::CFG_GAIN_K: begin
        lo = 32'h8000_0000; hi = 32'h7fff_ffff; dflt = dap_pkg::RST_GAIN_K;
      end
      dap_pkg::CFG_TWO_DAMPING_TIME: begin
        lo = '0; hi = 32'h7fff_ffff; dflt = 32'(dap_pkg::RST_TWO_DAMPING_TIME);
      end
      dap_pkg::CFG_TIME_CONST_SQUARED: begin
        lo = '0; hi = 32'h7fff_ffff; dflt = 32'(dap_pkg::RST_TIME_CONST_SQUARED);
      end
      dap_pkg::CFG_MAX_POSITION: begin
        lo = '0; hi = 32'h7fff_ffff; dflt = 32'(dap_pkg::RST_MAX_POSITION);
      end
      dap_pkg::CFG_MIN_VELOCITY: begin
        lo = 32'h8000_0000; hi = '0; dflt = dap_pkg::RST_MIN_VELOCITY;
      end
      default: begin
        lo = '0; hi = 32'h7fff_ffff; dflt = 32'(dap_pkg::RST_MAX_VELOCITY);
      end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return $urandom;
    return dflt + $signed($urandom_range(0, 2 * (dflt[31] ? -dflt : dflt) / 4 + 8))
      - (dflt[31] ? -dflt : dflt) / 4;
  endfunction

  task automatic random_request();
    int r;
    logic [2:0] md;
    logic [31:0] ts, val;
    logic [7:0] fs;
    stim_row_t row;
    r = $urandom_range(0, 99);
    if (r < 48) md = dap_pkg::MODE_TICK;
    else if (r < 68) md = dap_pkg::MODE_SET_VEL;
    else if (r < 82) md = dap_pkg::MODE_ENABLE;
    else if (r < 88) md = dap_pkg::MODE_DISABLE;
    else if (r < 95) md = dap_pkg::MODE_LOAD_POS;
    else md = 3'($urandom_range(5, 7));
    r = $urandom_range(0, 99);
    if (r < 10) ts = $urandom_range(0, 63);
    else if (r < 25) ts = $urandom;
    else ts = 32'h0100_0000 >> $urandom_range(0, 12);
    r = $urandom_range(0, 199);
    if (r < 3) fs = 8'd255;
    else if (r < 6) fs = 8'd0;
    else if (r < 30) fs = 8'($urandom_range(5, 200));
    else fs = 8'($urandom_range(1, 4));
    if (md != dap_pkg::MODE_TICK && $urandom_range(0, 3) == 0) fs = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 25) val = $urandom;
    else val = $urandom_range(0, 32'd13107200) - 32'd6553600;
    row = '{md, ts, fs, val, 1'b0, '0, '0, 1'b0};
    run_row(row);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("drive_axis_pt2_simulator_unit regression: fail");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      if ($urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 30);
      end else begin
        out_stall <= 1'b1;
        stall_left <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    axis_state_t e;
    if (!rst && out_valid && !out_stall) begin
      if (axis_q.size() == 0) begin
        report("unexpected result", position, 32'd0);
      end else begin
        e = axis_q.pop_front();
        if (position !== e.pos) report("position", position, e.pos);
        if (velocity !== e.vel) report("velocity", velocity, e.vel);
        if (enabled !== e.en) report("enabled", 32'(enabled), 32'(e.en));
      end
    end
  end

  stim_row_t directed[22];

  initial begin
    directed = '{
      '{dap_pkg::MODE_TICK, 32'h0100_0000, 8'd1, 32'd0, 1'b1, 32'sd0, 32'sd0, 1'b0},
      '{MODE_UNDEF5, 32'hffff_ffff, 8'd255, 32'hffff_ffff, 1'b1, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_LOAD_POS, 32'd0, 8'd1, 32'h7fff_ffff, 1'b1, 32'sd65536000, 32'sd0,
        1'b0},
      '{dap_pkg::MODE_LOAD_POS, 32'd0, 8'd1, 32'h8000_0000, 1'b1, -32'sd65536000, 32'sd0,
        1'b0},
      '{dap_pkg::MODE_LOAD_POS, 32'd0, 8'd1, 32'd12345, 1'b1, 32'sd12345, 32'sd0, 1'b0},
      '{dap_pkg::MODE_ENABLE, 32'd0, 8'd1, 32'd0, 1'b1, 32'sd12345, 32'sd0, 1'b1},
      '{dap_pkg::MODE_SET_VEL, 32'd0, 8'd1, 32'd6553600, 1'b1, 32'sd12345, 32'sd0, 1'b1},
      '{dap_pkg::MODE_TICK, 32'h0010_0000, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'h0100_0000, 8'd0, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'hffff_ffff, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_SET_VEL, 32'd0, 8'd1, 32'h8000_0000, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'hffff_ffff, 8'd4, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'h0100_0000, 8'd255, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{MODE_UNDEF6, 32'd0, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{MODE_UNDEF7, 32'd0, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_SET_VEL, 32'd0, 8'd1, 32'h7fff_ffff, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'h0040_0000, 8'd8, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_DISABLE, 32'd0, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'h0100_0000, 8'd2, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_ENABLE, 32'd0, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_TICK, 32'd1, 8'd200, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0},
      '{dap_pkg::MODE_LOAD_POS, 32'd0, 8'd1, 32'd0, 1'b1, 32'sd0, 32'sd0, 1'b0}
    };
    p_gain = dap_pkg::RST_GAIN_K;
    p_tdt = dap_pkg::RST_TWO_DAMPING_TIME;
    p_tcs = dap_pkg::RST_TIME_CONST_SQUARED;
    p_pmax = dap_pkg::RST_MAX_POSITION;
    p_vmin = dap_pkg::RST_MIN_VELOCITY;
    p_vmax = dap_pkg::RST_MAX_VELOCITY;
    p_pos = '0;
    p_vel = '0;
    p_prev = '0;
    p_cmd = '0;
    p_en = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) run_row(directed[i]);
    drain();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          // zero divisor
          write_reg(dap_pkg::CFG_TWO_DAMPING_TIME, 32'd0);
          write_reg(dap_pkg::CFG_TIME_CONST_SQUARED, 32'd0);
        end
        2: begin
          // crossed velocity limits
          write_reg(dap_pkg::CFG_MIN_VELOCITY, 32'h0001_0000);
          write_reg(dap_pkg::CFG_MAX_VELOCITY, 32'd0);
          write_reg(dap_pkg::CFG_TWO_DAMPING_TIME, 32'(dap_pkg::RST_TWO_DAMPING_TIME));
          write_reg(dap_pkg::CFG_TIME_CONST_SQUARED, 32'(dap_pkg::RST_TIME_CONST_SQUARED));
        end
        3: begin
          write_reg(dap_pkg::CFG_GAIN_K, 32'h7fff_ffff);
          write_reg(dap_pkg::CFG_MIN_VELOCITY, 32'h8000_0000);
          write_reg(dap_pkg::CFG_MAX_VELOCITY, 32'h7fff_ffff);
          write_reg(dap_pkg::CFG_MAX_POSITION, 32'h7fff_ffff);
        end
        4: begin
          write_reg(dap_pkg::CFG_GAIN_K, 32'h8000_0000);
          write_reg(dap_pkg::CFG_MAX_POSITION, 32'd0);
          write_reg(dap_pkg::CFG_TWO_DAMPING_TIME, 32'h7fff_ffff);
          write_reg(dap_pkg::CFG_TIME_CONST_SQUARED, 32'h7fff_ffff);
        end
        default: begin
          for (int k = 0; k < 6; k++) begin
            write_reg(dap_pkg::cfg_idx_t'(k), pick_reg(dap_pkg::cfg_idx_t'(k)));
          end
        end
      endcase
      run_row('{dap_pkg::MODE_ENABLE, 32'd0, 8'd1, 32'd0, 1'b0, 32'sd0, 32'sd0, 1'b0});
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      drain();
    end
    repeat (300) @(posedge clk);
    if (errors == 0 && axis_q.size() == 0) begin
      $display("drive_axis_pt2_simulator_unit regression: pass");
    end else begin
      $display("drive_axis_pt2_simulator_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dap_pkg.sv
hw/rtl/dap_mac.sv
hw/rtl/dap_div.sv
hw/rtl/drive_axis_pt2_simulator_unit.sv
tb/sv/tb_top.sv
